@@ rtl/rfc_pkg.sv @@
`timescale 1ns / 1ps

package rfc_pkg;

  // Commands below this code are run as execute requests
  localparam logic [7:0] EXEC_LIMIT = 8'd16;

  // Byte count saturates here
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Shortest frame that gives a verdict, and shortest with a full header
  localparam logic [15:0] MIN_REPORTED = 16'd3;
  localparam logic [15:0] MIN_HEADER   = 16'd6;

  // Frame positions of the kept bytes
  localparam logic [15:0] POS_START    = 16'd0;
  localparam logic [15:0] POS_ADDRESS  = 16'd2;
  localparam logic [15:0] POS_LEN_HIGH = 16'd3;
  localparam logic [15:0] POS_LEN_LOW  = 16'd4;
  localparam logic [15:0] POS_COMMAND  = 16'd5;
  localparam logic [15:0] POS_ARG0     = 16'd6;
  localparam logic [15:0] POS_ARG1     = 16'd7;
  localparam logic [15:0] POS_ARG2     = 16'd8;

  // Configuration register indexes
  localparam logic [1:0] CFG_BOARD_ADDRESS     = 2'd0;
  localparam logic [1:0] CFG_START_BYTE        = 2'd1;
  localparam logic [1:0] CFG_STATUS_QUERY_CODE = 2'd2;

  typedef enum logic [2:0] {
    VERDICT_NOADDR      = 3'd0,
    VERDICT_HEADER      = 3'd1,
    VERDICT_CHECKSUM    = 3'd2,
    VERDICT_LENGTH      = 3'd3,
    VERDICT_EXECUTE     = 3'd4,
    VERDICT_STATUS      = 3'd5,
    VERDICT_UNSUPPORTED = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [7:0] board_address;
    logic [7:0] start_byte;
    logic [7:0] status_query_code;
  } cfg_t;

  // Header of the frame as seen once the last byte is stored
  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  address_seen;
    logic [15:0] declared_length;
    logic [7:0]  command_seen;
    logic [7:0]  checksum;
    logic [7:0]  running_sum;
    logic [15:0] total;
  } check_t;

endpackage

@@ rtl/rfc_classify.sv @@
`timescale 1ns / 1ps

module rfc_classify (
  input  rfc_pkg::cfg_t     cfg,
  input  rfc_pkg::check_t   chk,
  output rfc_pkg::verdict_t verdict
);

  // Checks in priority order: address, start, checksum, length, then command class
  always_comb begin
    if (chk.address_seen != cfg.board_address) begin
      verdict = rfc_pkg::VERDICT_NOADDR;
    end else if (chk.first_byte != cfg.start_byte) begin
      verdict = rfc_pkg::VERDICT_HEADER;
    end else if (chk.checksum != chk.running_sum) begin
      verdict = rfc_pkg::VERDICT_CHECKSUM;
    end else if (chk.total < rfc_pkg::MIN_HEADER || chk.declared_length != chk.total) begin
      verdict = rfc_pkg::VERDICT_LENGTH;
    end else if (chk.command_seen < rfc_pkg::EXEC_LIMIT) begin
      verdict = rfc_pkg::VERDICT_EXECUTE;
    end else if (chk.command_seen == cfg.status_query_code) begin
      verdict = rfc_pkg::VERDICT_STATUS;
    end else begin
      verdict = rfc_pkg::VERDICT_UNSUPPORTED;
    end
  end

endmodule

@@ rtl/request_frame_checker.sv @@
`timescale 1ns / 1ps

// Request frame checker. Takes one frame byte per cycle on the input
// channel, with frame_end high on the last (checksum) byte, and gives
// one verdict word per frame of three bytes or more, in the cycle after
// its last byte is taken; shorter frames are dropped without a word.
// For every byte the running sum, byte count and header capture
// update at the input edge, and the verdict is formed by a single
// compare chain into the output register. The input stalls only on a
// last byte while the previous verdict is still held by a stall from
// downstream. Configuration writes take effect at once; the user must
// make them between frames, as the block itself does not enforce it.
module request_frame_checker (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_write_enable,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       frame_end,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] verdict,
  output logic [7:0] command_code,
  output logic [7:0] argument_first,
  output logic [7:0] argument_second,
  output logic [7:0] argument_third
);

  rfc_pkg::cfg_t     cfg;
  rfc_pkg::check_t   chk;
  rfc_pkg::verdict_t verdict_next;

  logic [7:0]  running_sum;
  logic [15:0] byte_count;
  logic [7:0]  first_byte;
  logic [7:0]  address_seen;
  logic [15:0] declared_length;
  logic [7:0]  command_seen;
  logic [7:0]  argument_bytes [3];

  logic [7:0]  first_eff;
  logic [7:0]  address_eff;
  logic [15:0] length_eff;
  logic [7:0]  command_eff;
  logic [7:0]  arg0_eff;
  logic [7:0]  arg1_eff;
  logic [7:0]  arg2_eff;
  logic [15:0] total;
  logic        accept;
  logic        result_fire;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        rfc_pkg::CFG_BOARD_ADDRESS:     cfg.board_address     <= cfg_data;
        rfc_pkg::CFG_START_BYTE:        cfg.start_byte        <= cfg_data;
        rfc_pkg::CFG_STATUS_QUERY_CODE: cfg.status_query_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: only a last byte waits for the output slot
  assign in_stall    = out_valid && out_stall && frame_end;
  assign accept      = in_valid && !in_stall;
  assign result_fire = accept && frame_end && (byte_count >= rfc_pkg::MIN_REPORTED - 16'd1);

  // Kept bytes with the current byte stored into its position
  always_comb begin
    first_eff   = (byte_count == rfc_pkg::POS_START)   ? rx_byte : first_byte;
    address_eff = (byte_count == rfc_pkg::POS_ADDRESS) ? rx_byte : address_seen;
    length_eff  = declared_length;
    if (byte_count == rfc_pkg::POS_LEN_HIGH) length_eff[15:8] = rx_byte;
    if (byte_count == rfc_pkg::POS_LEN_LOW)  length_eff[7:0]  = rx_byte;
    command_eff = (byte_count == rfc_pkg::POS_COMMAND) ? rx_byte : command_seen;
    arg0_eff    = (byte_count == rfc_pkg::POS_ARG0) ? rx_byte : argument_bytes[0];
    arg1_eff    = (byte_count == rfc_pkg::POS_ARG1) ? rx_byte : argument_bytes[1];
    arg2_eff    = (byte_count == rfc_pkg::POS_ARG2) ? rx_byte : argument_bytes[2];
  end

  // Frame length including the last byte, saturated
  assign total = (byte_count == rfc_pkg::COUNT_MAX) ? rfc_pkg::COUNT_MAX
                                                    : byte_count + 16'd1;

  always_comb begin
    chk.first_byte      = first_eff;
    chk.address_seen    = address_eff;
    chk.declared_length = length_eff;
    chk.command_seen    = command_eff;
    chk.checksum        = rx_byte;
    chk.running_sum     = running_sum;
    chk.total           = total;
  end

  rfc_classify u_classify (
    .cfg     (cfg),
    .chk     (chk),
    .verdict (verdict_next)
  );

  // Frame state: accumulate, cleared after every last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= '0;
      byte_count        <= '0;
      first_byte        <= '0;
      address_seen      <= '0;
      declared_length   <= '0;
      command_seen      <= '0;
      argument_bytes[0] <= '0;
      argument_bytes[1] <= '0;
      argument_bytes[2] <= '0;
    end else if (accept) begin
      if (frame_end) begin
        running_sum       <= '0;
        byte_count        <= '0;
        first_byte        <= '0;
        address_seen      <= '0;
        declared_length   <= '0;
        command_seen      <= '0;
        argument_bytes[0] <= '0;
        argument_bytes[1] <= '0;
        argument_bytes[2] <= '0;
      end else begin
        running_sum       <= running_sum + rx_byte;
        if (byte_count != rfc_pkg::COUNT_MAX) byte_count <= byte_count + 16'd1;
        first_byte        <= first_eff;
        address_seen      <= address_eff;
        declared_length   <= length_eff;
        command_seen      <= command_eff;
        argument_bytes[0] <= arg0_eff;
        argument_bytes[1] <= arg1_eff;
        argument_bytes[2] <= arg2_eff;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      verdict         <= verdict_next;
      command_code    <= command_eff;
      argument_first  <= arg0_eff;
      argument_second <= arg1_eff;
      argument_third  <= arg2_eff;
    end
  end

`ifndef SYNTHESIS
  // A reported frame always lands a word in the output register
  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    result_fire |=> out_valid)
    else $error("verdict word lost after last byte");

  // The frame state is empty after any accepted last byte
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> (byte_count == 16'd0 && running_sum == 8'd0))
    else $error("frame state not cleared after last byte");

  // The input stalls only on a last byte while a word is held
  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (frame_end && out_valid))
    else $error("input stalled on a middle byte");

  // A held word is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !result_fire)
    else $error("held verdict overwritten");
`endif

endmodule
